### sv/assert_macros.svh
// Assertion helpers used by quaternion_normalize.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QN_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define QN_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define QN_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define QN_ASSERT_RST(lbl, clk_s, prop, msg)
`endif
`endif

### sv/qn_pkg.sv
`default_nettype none
package qn_pkg;
  localparam int COMPONENT_BITS_DEF = 16;
  localparam int QB = 15;          // quotient bits, 0..16384
  localparam int OUT_W = 16;       // Q1.14 result width
  localparam logic [31:0] MIN_LEN_RESET = 32'd1;

  typedef struct packed {
    logic valid;
    logic degenerate;
  } ctl_t;
endpackage
`default_nettype wire

### sv/quaternion_normalize.sv
`default_nettype none
`include "assert_macros.svh"
// Quaternion normalizer. Each input word carries w, x, y, z as signed
// fixed-point components (Q4.12 at 16 bits); each output word carries the
// unit quaternion in signed Q1.14, rounded to nearest (ties away from zero)
// and never beyond +-1.0. When the sum of squares is at or below
// min_length_sq (register 0, byte address 0, reset 1, raw units of the input
// squared) the four outputs are zero and tuser flags the word as degenerate.
// One word is taken every cycle unless back pressure on the output stalls
// the whole row. Registered steps, in order: the squares, the sum and
// threshold, a row of 15 cells that each settle one quotient bit by add and
// compare, and the output register.
module quaternion_normalize #(
  parameter int COMPONENT_BITS = qn_pkg::COMPONENT_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  // w_in, x_in, y_in, z_in from bit 0 up, zero padded to whole bytes
  input  wire  [((4*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // w_out, x_out, y_out, z_out from bit 0 up
  output logic [4*qn_pkg::OUT_W-1:0]    m_tdata,
  // degenerate
  output logic                          m_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [2:0]                    paddr,
  input  wire  [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import qn_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int LW = 2 * CB + 37;

  logic [31:0] min_len;
  logic        en;
  logic [3:0][CB-1:0] comp;

  ctl_t                   ctl   [QB+1];
  logic [3:0]             neg   [QB+1];
  logic [LW-1:0]          s_v   [QB+1];
  logic [3:0][LW-1:0]     r_v   [QB+1];
  logic [3:0][LW-1:0]     l_v   [QB+1];
  logic [3:0][LW-1:0]     t_v   [QB+1];
  logic [3:0][QB-1:0]     q_v   [QB+1];

  // Config register: index is paddr[2]; only index 0 exists.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      min_len <= pwdata;
    end
  end
  assign prdata = paddr[2] ? 32'd0 : min_len;

  // Advance the whole row whenever the output register is free or drains.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      comp[k] = s_tdata[k*CB +: CB];
    end
  end

  qn_front #(.CB(CB), .LW(LW)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .comp_in(comp), .min_len(min_len),
    .ctl_out(ctl[0]), .neg_out(neg[0]), .s_out(s_v[0]), .r_out(r_v[0]),
    .l_out(l_v[0]), .t_out(t_v[0]), .q_out(q_v[0])
  );

  // One cell per quotient bit, most significant first.
  for (genvar i = 0; i < QB; i++) begin : g_cell
    qn_cell #(.LW(LW), .BIT(QB - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl[i]), .neg_in(neg[i]), .s_in(s_v[i]), .r_in(r_v[i]),
      .l_in(l_v[i]), .t_in(t_v[i]), .q_in(q_v[i]),
      .ctl_out(ctl[i+1]), .neg_out(neg[i+1]), .s_out(s_v[i+1]),
      .r_out(r_v[i+1]), .l_out(l_v[i+1]), .t_out(t_v[i+1]), .q_out(q_v[i+1])
    );
  end

  // Output register: apply signs, zero degenerate words.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= ctl[QB].degenerate;
      for (int k = 0; k < 4; k++) begin
        if (ctl[QB].degenerate) begin
          m_tdata[k*OUT_W +: OUT_W] <= '0;
        end else if (neg[QB][k]) begin
          m_tdata[k*OUT_W +: OUT_W] <= OUT_W'(0) - OUT_W'(q_v[QB][k]);
        end else begin
          m_tdata[k*OUT_W +: OUT_W] <= OUT_W'(q_v[QB][k]);
        end
      end
    end
  end

  `QN_ASSERT(a_degen_zero, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == '0), "degenerate word carries data")
  `QN_ASSERT(a_w_range, clk, rst, (m_tvalid && !m_tuser) |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384), "w_out beyond unit range")
  `QN_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> !m_tvalid, "output valid right after reset")
endmodule
`default_nettype wire

### sv/qn_front.sv
`default_nettype none
module qn_front #(
  parameter int CB = 16,
  parameter int LW = 2 * 16 + 37
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  wire                      in_valid,
  input  wire  [3:0][CB-1:0]       comp_in,
  input  wire  [31:0]              min_len,
  output qn_pkg::ctl_t             ctl_out,
  output logic [3:0]               neg_out,
  output logic [LW-1:0]            s_out,
  output logic [3:0][LW-1:0]       r_out,
  output logic [3:0][LW-1:0]       l_out,
  output logic [3:0][LW-1:0]       t_out,
  output logic [3:0][qn_pkg::QB-1:0] q_out
);
  import qn_pkg::*;

  localparam int SQW = 2 * CB;
  localparam int SW  = 2 * CB + 2;

  logic              v1;
  logic [3:0]        neg1;
  logic [3:0][SQW-1:0] sq1;
  logic [3:0][CB-1:0]  mag;
  logic [SW-1:0]     s_sum;
  logic [LW-1:0]     s_ext;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = comp_in[k][CB-1] ? (~comp_in[k] + CB'(1)) : comp_in[k];
    end
    s_sum = SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]) + SW'(sq1[3]);
    s_ext = LW'(s_sum);
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        neg1[k] <= comp_in[k][CB-1];
        sq1[k]  <= SQW'(mag[k]) * SQW'(mag[k]);
      end
    end
  end

  // sum, threshold and seed values for the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid      <= v1;
      ctl_out.degenerate <= s_ext <= LW'(min_len);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_out <= neg1;
      s_out   <= s_ext;
      for (int k = 0; k < 4; k++) begin
        r_out[k] <= LW'(sq1[k]) << 30;
        l_out[k] <= s_ext;
        t_out[k] <= LW'(0) - s_ext;
        q_out[k] <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/qn_cell.sv
`default_nettype none
module qn_cell #(
  parameter int LW = 2 * 16 + 37,
  parameter int BIT = 0
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      en,
  input  qn_pkg::ctl_t             ctl_in,
  input  wire  [3:0]               neg_in,
  input  wire  [LW-1:0]            s_in,
  input  wire  [3:0][LW-1:0]       r_in,
  input  wire  [3:0][LW-1:0]       l_in,
  input  wire  [3:0][LW-1:0]       t_in,
  input  wire  [3:0][qn_pkg::QB-1:0] q_in,
  output qn_pkg::ctl_t             ctl_out,
  output logic [3:0]               neg_out,
  output logic [LW-1:0]            s_out,
  output logic [3:0][LW-1:0]       r_out,
  output logic [3:0][LW-1:0]       l_out,
  output logic [3:0][LW-1:0]       t_out,
  output logic [3:0][qn_pkg::QB-1:0] q_out
);
  import qn_pkg::*;

  // Trying bit BIT: (2q'-1)^2 S = L + (2q-1)S*2^(BIT+2) + S*2^(2BIT+2)
  logic signed [LW-1:0] lc  [4];
  logic [3:0]           acc;
  logic [LW-1:0]        s_sq;
  logic [LW-1:0]        s_lin;

  always_comb begin
    s_sq  = s_in << (2 * BIT + 2);
    s_lin = s_in << (BIT + 1);
    for (int k = 0; k < 4; k++) begin
      lc[k]  = $signed(l_in[k]) + ($signed(t_in[k]) <<< (BIT + 2)) + $signed(s_sq);
      acc[k] = lc[k] <= $signed(r_in[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_out <= neg_in;
      s_out   <= s_in;
      r_out   <= r_in;
      for (int k = 0; k < 4; k++) begin
        if (acc[k]) begin
          l_out[k] <= lc[k];
          t_out[k] <= t_in[k] + s_lin;
          q_out[k] <= q_in[k] | (QB'(1) << BIT);
        end else begin
          l_out[k] <= l_in[k];
          t_out[k] <= t_in[k];
          q_out[k] <= q_in[k];
        end
      end
    end
  end
endmodule
`default_nettype wire

### bench/quaternion_normalize_checker.sv
`default_nettype none
// Watches both streams and the register port, predicts each output word
// from the input word and the current threshold, and compares in order.
module quaternion_normalize_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire  [63:0] s_tdata,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [63:0] m_tdata,
  input  wire         m_tuser,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  input  wire         pready,
  output int          errors,
  output int          pending
);

  localparam int unsigned UNIT = 16384;
  localparam logic [2:0] ADDR_MIN_LENGTH_SQ = 3'd0;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        degen;
  } unit_quat_t;

  unit_quat_t  unit_q[$];
  logic [31:0] min_len_sq;

  // largest q with (2q-1)^2 * s <= mag^2 * 2^30, i.e. round half up
  function automatic int unsigned scale_component(longint unsigned mag,
                                                  longint unsigned s);
    logic [127:0]  rhs;
    logic [127:0]  lhs;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    longint unsigned odd;
    rhs = 128'(mag * mag) << 30;
    lo = 0;
    hi = UNIT;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 2 * longint'(mid) - 1;
      lhs = 128'(s) * 128'(odd * odd);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic unit_quat_t normalize(logic [63:0] word, logic [31:0] thresh);
    unit_quat_t      r;
    longint unsigned mag [4];
    logic            neg [4];
    longint unsigned s;
    logic [15:0]     comp;
    logic [15:0]     outv [4];
    int unsigned     q;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      comp   = word[16*i +: 16];
      neg[i] = comp[15];
      mag[i] = neg[i] ? (longint'(65536) - comp) : longint'(comp);
      s += mag[i] * mag[i];
    end
    if (s <= longint'(thresh)) begin
      r = '0;
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = scale_component(mag[i], s);
      if (q > UNIT) q = UNIT;
      outv[i] = neg[i] ? 16'(-q) : 16'(q);
    end
    r.w = outv[0];
    r.x = outv[1];
    r.y = outv[2];
    r.z = outv[3];
    r.degen = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    unit_quat_t want;
    unit_quat_t got;
    if (rst) begin
      min_len_sq = 32'd1;
      unit_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_MIN_LENGTH_SQ)
        min_len_sq = pwdata;
      if (s_tvalid && s_tready)
        unit_q.push_back(normalize(s_tdata, min_len_sq));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser};
        if (unit_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word w=%h x=%h y=%h z=%h degenerate=%b",
                   $realtime, got.w, got.x, got.y, got.z, got.degen);
        end else begin
          want = unit_q.pop_front();
          if (got.w !== want.w) begin
            errors++;
            $display("%0t: w_out expected %h actual %h", $realtime, want.w, got.w);
          end
          if (got.x !== want.x) begin
            errors++;
            $display("%0t: x_out expected %h actual %h", $realtime, want.x, got.x);
          end
          if (got.y !== want.y) begin
            errors++;
            $display("%0t: y_out expected %h actual %h", $realtime, want.y, got.y);
          end
          if (got.z !== want.z) begin
            errors++;
            $display("%0t: z_out expected %h actual %h", $realtime, want.z, got.z);
          end
          if (got.degen !== want.degen) begin
            errors++;
            $display("%0t: degenerate expected %b actual %b", $realtime,
                     want.degen, got.degen);
          end
        end
      end
    end
    pending = unit_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    min_len_sq = 32'd1;
  end

endmodule
`default_nettype wire

### bench/tb_quaternion_normalize.sv
`default_nettype none
// Stimulus and verdict for the quaternion normalizer; all checking lives in
// the checker instance beside the block.
module tb_quaternion_normalize;

  localparam logic [2:0] ADDR_MIN_LENGTH_SQ = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;
  localparam int PIPE_DRAIN = 30;   // comfortably above the pipeline latency

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [63:0] s_tdata = '0;       // w_in, x_in, y_in, z_in from bit 0 up
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  wire  [63:0] m_tdata;            // w_out, x_out, y_out, z_out from bit 0 up
  wire         m_tuser;            // degenerate
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  int   errors;
  int   pending;
  logic in_fire = 1'b0;
  int   hold_req = 0;      // long receiver hold-off requested by the sender
  bit   no_idle = 0;       // stretch with neither side idling

  always #2 clk = ~clk;

  quaternion_normalize DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  quaternion_normalize_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  // Register the input handshake so the sender can look at it at the falling edge.
  always @(posedge clk) in_fire <= s_tvalid & s_tready;

  // Receiver: mostly ready, short stalls often, long ones rarely; honor a
  // requested hold-off by counting cycles here.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 9) < 2) begin
        m_tready <= 1'b0;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                   : $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Register write with a setup phase and an access phase, issued only while the block is idle.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold a word on the bus until taken; keep tvalid high when the next
  // word follows without a gap.
  task automatic send_word(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    int gap;
    s_tdata  <= {z, y, x, w};
    s_tvalid <= 1'b1;
    do @(negedge clk); while (!in_fire);
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] rand_component(int kind);
    int pick;
    case (kind)
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 16)) - 8);
      2: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hffff;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic send_random;
    int kind;
    logic [15:0] c [4];
    int major;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      if (kind < 4) c[i] = rand_component(0);
      else if (kind < 6) c[i] = rand_component(1);
      else if (kind == 6) c[i] = rand_component(2);
      else c[i] = rand_component(3);
    end
    // one dominant axis with small residue on the others
    if (kind == 7) begin
      major = $urandom_range(0, 3);
      c[major] = 16'($urandom_range(0, 1) ? 32767 : -32768);
    end
    send_word(c[0], c[1], c[2], c[3]);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic random_phase(input logic [31:0] thresh, input int count);
    drain();
    reg_write(ADDR_MIN_LENGTH_SQ, thresh);
    for (int i = 0; i < count; i++) send_random();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset threshold of 1.
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // all zero: degenerate
    send_word(16'h0001, 16'h0000, 16'h0000, 16'h0000);  // sum equals threshold
    send_word(16'h0001, 16'h0001, 16'h0000, 16'h0000);  // just above threshold
    send_word(16'hffff, 16'h0000, 16'h0000, 16'h0000);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // most negative everywhere
    send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_word(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_word(16'h1000, 16'h0000, 16'h0000, 16'h0000);  // one nonzero axis in each word
    send_word(16'h0000, 16'h1000, 16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000, 16'hf000, 16'h0000);
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_word(16'h0003, 16'h0004, 16'h0000, 16'h0000);  // exact 3-4-5
    send_word(16'h0001, 16'h0001, 16'h0001, 16'h0001);  // exact halves
    send_word(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_word(16'h0001, 16'h0002, 16'h0002, 16'h0000);  // exact thirds
    send_word(16'h0001, 16'h0001, 16'h0001, 16'h0000);
    send_word(16'h7fff, 16'h0001, 16'h0000, 16'h0000);  // near saturation
    send_word(16'h8000, 16'hffff, 16'h0001, 16'hffff);
    send_word(16'h5555, 16'haaaa, 16'h3333, 16'hcccc);

    // Threshold zero: only the all-zero word is degenerate.
    random_phase(32'd0, 160);
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // Maximum threshold: everything degenerate except the largest sums.
    random_phase(32'hffff_ffff, 140);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    // Long receiver hold-off while words keep coming, to back up the pipe.
    hold_req = 300;
    for (int i = 0; i < 60; i++) send_random();

    // A write to an unmapped address must leave the threshold alone.
    drain();
    reg_write(ADDR_UNMAPPED, 32'd0);
    for (int i = 0; i < 40; i++) send_random();

    // Back-to-back stretch with no idling on either side.
    random_phase(32'($urandom), 0);
    no_idle = 1;
    for (int i = 0; i < 160; i++) send_random();
    no_idle = 0;

    // Small threshold around the tiny-magnitude words; pause mid-way until empty.
    random_phase(32'($urandom_range(0, 64)), 80);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 80; i++) send_random();

    random_phase(32'($urandom_range(1 << 20, 1 << 28)), 160);
    random_phase(32'd1, 248);

    drain();
    if (errors == 0)
      $display("quaternion_normalize regression: pass");
    else
      $display("quaternion_normalize regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("quaternion_normalize regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
